@@ rtl/core/dmpi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpi_pkg
// Shared types, constants and helpers for the dual-motor PI speed and
// position controller.
// ----------------------------------------------------------------------------
package dmpi_pkg;

    // Widths of the word fields.
    localparam int unsigned OPC_W   = 4;
    localparam int unsigned SPD_W   = 16;
    localparam int unsigned ENC_W   = 32;
    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned CFG_IW  = 3;
    localparam int unsigned CFG_DW  = 16;
    localparam int unsigned STEP_W  = 4;

    // Datapath widths: gain operand, inner sum, full product.
    localparam int unsigned GAIN_W  = 17;
    localparam int unsigned INNER_W = 35;
    localparam int unsigned PROD_W  = GAIN_W + INNER_W;
    localparam int unsigned FRAC_W  = 28;
    localparam int unsigned QI_W    = 14;

    // Duty clamp: magnitudes from 101 * 2^28 up saturate to 100 percent.
    localparam logic [PROD_W-1:0] CLAMP_LIM = PROD_W'(101) << FRAC_W;
    localparam logic signed [DUTY_W-1:0] DUTY_MAX = DUTY_W'(100);
    localparam logic signed [DUTY_W-1:0] DUTY_MIN = -DUTY_W'(100);

    // Register reset values.
    localparam logic [CFG_DW-1:0] KP_LEFT_RST   = 16'd14909;
    localparam logic [CFG_DW-1:0] KI_LEFT_RST   = 16'd246;
    localparam logic [CFG_DW-1:0] KP_RIGHT_RST  = 16'd16384;
    localparam logic [CFG_DW-1:0] KI_RIGHT_RST  = 16'd246;
    localparam logic [CFG_DW-1:0] ROT_SPD_RST   = 16'd20;
    localparam logic [CFG_DW-1:0] STR_SPD_RST   = 16'd25;

    // Configuration register indexes.
    typedef enum logic [CFG_IW-1:0] {
        REG_KP_LEFT  = 3'd0,
        REG_KI_LEFT  = 3'd1,
        REG_KP_RIGHT = 3'd2,
        REG_KI_RIGHT = 3'd3,
        REG_ROT_SPD  = 3'd4,
        REG_STR_SPD  = 3'd5
    } t_reg_idx;

    // Command opcodes.
    typedef enum logic [OPC_W-1:0] {
        OPC_TICK    = 4'd0,
        OPC_STOP    = 4'd1,
        OPC_AT_POS  = 4'd2,
        OPC_FWD     = 4'd3,
        OPC_REV     = 4'd4,
        OPC_CCW     = 4'd5,
        OPC_CW      = 4'd6,
        OPC_SET_L   = 4'd7,
        OPC_SET_R   = 4'd8,
        OPC_CCW_POS = 4'd9,
        OPC_CW_POS  = 4'd10,
        OPC_FWD_POS = 4'd11,
        OPC_REV_POS = 4'd12
    } t_opcode;

    // Datapath operations driven by the control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ERR,
        OP_SUM,
        OP_MUL1,
        OP_INNER,
        OP_MUL2,
        OP_ABS,
        OP_FIN,
        OP_OUT
    } t_dp_op;

    // Jump conditions of the sequencer.
    typedef enum logic [1:0] {
        CND_NONE,
        CND_ZERO,
        CND_BUSY
    } t_cond;

    // Motor selected by a control word.
    typedef enum logic {
        MOT_L = 1'b0,
        MOT_R = 1'b1
    } t_motor;

    // One control word of the microprogram.
    typedef struct packed {
        t_dp_op             op;
        t_motor             motor;
        t_cond              cond;
        logic [STEP_W-1:0]  target;
    } t_ctrl;

    // Status fed back from the datapath to the sequencer.
    typedef struct packed {
        logic zero;
        logic out_busy;
    } t_stat;

    // Saturate a 17-bit signed value to 16 bits.
    function automatic logic signed [SPD_W-1:0] sat16(input logic signed [SPD_W:0] x);
        logic signed [SPD_W-1:0] r;
        if (x[SPD_W] != x[SPD_W-1]) begin
            r = x[SPD_W] ? {1'b1, {(SPD_W-1){1'b0}}} : {1'b0, {(SPD_W-1){1'b1}}};
        end else begin
            r = x[SPD_W-1:0];
        end
        return r;
    endfunction

    // 16-bit two's complement negation, wrapping at the most negative value.
    function automatic logic signed [SPD_W-1:0] neg16(input logic signed [SPD_W-1:0] x);
        return SPD_W'(SPD_W'(0) - x);
    endfunction

endpackage

@@ rtl/core/dmpi_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpi_if
// Valid/ready channels of the controller: command words in, duty words out.
// ----------------------------------------------------------------------------
interface dmpi_in_if;
    logic                               valid;
    logic                               ready;
    logic [dmpi_pkg::OPC_W-1:0]         opcode;
    logic signed [dmpi_pkg::SPD_W-1:0]  param;
    logic signed [dmpi_pkg::SPD_W-1:0]  rpm_left;
    logic signed [dmpi_pkg::SPD_W-1:0]  rpm_right;
    logic [dmpi_pkg::ENC_W-1:0]         enc_count;

    modport source (output valid, opcode, param, rpm_left, rpm_right, enc_count,
                    input ready);
    modport sink   (input valid, opcode, param, rpm_left, rpm_right, enc_count,
                    output ready);
endinterface

interface dmpi_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [dmpi_pkg::DUTY_W-1:0] duty_left;
    logic signed [dmpi_pkg::DUTY_W-1:0] duty_right;
    logic                               at_position;

    modport source (output valid, duty_left, duty_right, at_position, input ready);
    modport sink   (input valid, duty_left, duty_right, at_position, output ready);
endinterface

@@ rtl/core/dmpi_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpi_seq
// Step counter and microprogram ROM. One control word per step drives the
// datapath; conditional jumps skip the PI math for a zero target and hold
// the output step while the result register is still occupied.
// ----------------------------------------------------------------------------
module dmpi_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  dmpi_pkg::t_stat    i_stat,
    output dmpi_pkg::t_ctrl    o_ctrl,
    output logic               o_idle
);

    localparam logic [dmpi_pkg::STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [dmpi_pkg::STEP_W-1:0] STEP_FIN_L = 4'd7;
    localparam logic [dmpi_pkg::STEP_W-1:0] STEP_FIN_R = 4'd14;
    localparam logic [dmpi_pkg::STEP_W-1:0] STEP_OUT   = 4'd15;

    logic [dmpi_pkg::STEP_W-1:0] r_step;
    logic [dmpi_pkg::STEP_W-1:0] n_step;
    dmpi_pkg::t_ctrl             w_ctrl;
    logic                        w_jump;

    // Microprogram: left motor in steps 1-7, right motor in 8-14, output at 15.
    always_comb begin
        unique case (r_step)
            4'd0:  w_ctrl = '{dmpi_pkg::OP_NOP,   dmpi_pkg::MOT_L, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd1:  w_ctrl = '{dmpi_pkg::OP_ERR,   dmpi_pkg::MOT_L, dmpi_pkg::CND_ZERO, STEP_FIN_L};
            4'd2:  w_ctrl = '{dmpi_pkg::OP_SUM,   dmpi_pkg::MOT_L, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd3:  w_ctrl = '{dmpi_pkg::OP_MUL1,  dmpi_pkg::MOT_L, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd4:  w_ctrl = '{dmpi_pkg::OP_INNER, dmpi_pkg::MOT_L, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd5:  w_ctrl = '{dmpi_pkg::OP_MUL2,  dmpi_pkg::MOT_L, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd6:  w_ctrl = '{dmpi_pkg::OP_ABS,   dmpi_pkg::MOT_L, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd7:  w_ctrl = '{dmpi_pkg::OP_FIN,   dmpi_pkg::MOT_L, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd8:  w_ctrl = '{dmpi_pkg::OP_ERR,   dmpi_pkg::MOT_R, dmpi_pkg::CND_ZERO, STEP_FIN_R};
            4'd9:  w_ctrl = '{dmpi_pkg::OP_SUM,   dmpi_pkg::MOT_R, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd10: w_ctrl = '{dmpi_pkg::OP_MUL1,  dmpi_pkg::MOT_R, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd11: w_ctrl = '{dmpi_pkg::OP_INNER, dmpi_pkg::MOT_R, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd12: w_ctrl = '{dmpi_pkg::OP_MUL2,  dmpi_pkg::MOT_R, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd13: w_ctrl = '{dmpi_pkg::OP_ABS,   dmpi_pkg::MOT_R, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd14: w_ctrl = '{dmpi_pkg::OP_FIN,   dmpi_pkg::MOT_R, dmpi_pkg::CND_NONE, STEP_IDLE};
            4'd15: w_ctrl = '{dmpi_pkg::OP_OUT,   dmpi_pkg::MOT_R, dmpi_pkg::CND_BUSY, STEP_OUT};
        endcase
    end

    // Jump decision from the condition field and datapath status.
    always_comb begin
        unique case (w_ctrl.cond)
            dmpi_pkg::CND_ZERO: w_jump = i_stat.zero;
            dmpi_pkg::CND_BUSY: w_jump = i_stat.out_busy;
            default:            w_jump = 1'b0;
        endcase
    end

    // Next step: wait at idle for a tick, else jump or advance. Step 15 wraps to idle.
    always_comb begin
        if (r_step == STEP_IDLE) begin
            n_step = i_start ? (STEP_IDLE + 4'd1) : STEP_IDLE;
        end else if (w_jump) begin
            n_step = w_ctrl.target;
        end else begin
            n_step = r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = w_ctrl;
    assign o_idle = (r_step == STEP_IDLE);

endmodule

@@ rtl/core/dmpi_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpi_dp
// Datapath: configuration and controller state, command decode, the PI
// arithmetic around one shared multiplier, and the result register.
// ----------------------------------------------------------------------------
module dmpi_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration writes.
    input  logic                                i_cfg_we,
    input  logic [dmpi_pkg::CFG_IW-1:0]         i_cfg_idx,
    input  logic [dmpi_pkg::CFG_DW-1:0]         i_cfg_data,
    // Accepted command word.
    input  logic                                i_cmd_acc,
    input  logic [dmpi_pkg::OPC_W-1:0]          i_opcode,
    input  logic signed [dmpi_pkg::SPD_W-1:0]   i_param,
    input  logic signed [dmpi_pkg::SPD_W-1:0]   i_rpm_left,
    input  logic signed [dmpi_pkg::SPD_W-1:0]   i_rpm_right,
    input  logic [dmpi_pkg::ENC_W-1:0]          i_enc_count,
    // Microprogram control and status.
    input  dmpi_pkg::t_ctrl                     i_ctrl,
    output dmpi_pkg::t_stat                     o_stat,
    // Result word.
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [dmpi_pkg::DUTY_W-1:0]  o_duty_left,
    output logic signed [dmpi_pkg::DUTY_W-1:0]  o_duty_right,
    output logic                                o_at_position
);

    localparam int unsigned SW = dmpi_pkg::SPD_W;
    localparam int unsigned PW = dmpi_pkg::PROD_W;
    localparam int unsigned IW = dmpi_pkg::INNER_W;
    localparam int unsigned GW = dmpi_pkg::GAIN_W;

    // Configuration registers.
    logic [dmpi_pkg::CFG_DW-1:0] r_kp_l, r_ki_l, r_kp_r, r_ki_r;
    logic signed [SW-1:0]        r_rot_spd, r_str_spd;

    // Controller state.
    logic signed [SW-1:0]        r_tgt_l, r_tgt_r;
    logic signed [SW-1:0]        r_sum_l, r_sum_r;
    logic                        r_pos_mode;
    logic signed [SW-1:0]        r_pos_dist;
    logic [dmpi_pkg::ENC_W-1:0]  r_pos_start;
    logic                        r_out_valid;

    // Latched tick inputs and working registers.
    logic signed [SW-1:0]        r_rpm_l, r_rpm_r;
    logic [dmpi_pkg::ENC_W-1:0]  r_enc;
    logic signed [SW-1:0]        r_err, r_s;
    logic                        r_zero;
    logic signed [IW-1:0]        r_inner;
    logic signed [PW-1:0]        r_prod;
    logic [PW-1:0]               r_mag;
    logic                        r_neg;
    logic signed [dmpi_pkg::DUTY_W-1:0] r_duty_l, r_duty_r;
    logic signed [dmpi_pkg::DUTY_W-1:0] r_o_duty_l, r_o_duty_r;
    logic                        r_o_at_pos;

    // Combinational values.
    logic signed [SW-1:0]        w_tgt, w_rpm, w_sum;
    logic [dmpi_pkg::CFG_DW-1:0] w_kp, w_ki;
    logic signed [GW-1:0]        w_mul_a;
    logic signed [IW-1:0]        w_mul_b;
    logic signed [PW-1:0]        w_mul_p;
    logic                        w_over;
    logic [6:0]                  w_mag7;
    logic signed [dmpi_pkg::DUTY_W-1:0] w_duty;
    logic signed [SW-1:0]        w_sum_next;
    logic [dmpi_pkg::ENC_W-1:0]  w_moved, w_goal;
    logic                        w_done;
    logic                        w_busy;

    // Operand selection for the motor of the current step.
    always_comb begin
        if (i_ctrl.motor == dmpi_pkg::MOT_R) begin
            w_tgt = r_tgt_r;
            w_rpm = r_rpm_r;
            w_sum = r_sum_r;
            w_kp  = r_kp_r;
            w_ki  = r_ki_r;
        end else begin
            w_tgt = r_tgt_l;
            w_rpm = r_rpm_l;
            w_sum = r_sum_l;
            w_kp  = r_kp_l;
            w_ki  = r_ki_l;
        end
    end

    // Shared multiplier: ki * sum first, then kp * inner.
    always_comb begin
        if (i_ctrl.op == dmpi_pkg::OP_MUL2) begin
            w_mul_a = $signed({1'b0, w_kp});
            w_mul_b = r_inner;
        end else begin
            w_mul_a = $signed({1'b0, w_ki});
            w_mul_b = IW'(r_s);
        end
        w_mul_p = PW'(w_mul_a) * PW'(w_mul_b);
    end

    // Duty from the product magnitude, truncated toward zero, and the clamp.
    always_comb begin
        w_over = (r_mag >= dmpi_pkg::CLAMP_LIM);
        w_mag7 = r_mag[dmpi_pkg::FRAC_W+6:dmpi_pkg::FRAC_W];
        if (r_zero) begin
            w_duty = '0;
        end else if (w_over) begin
            w_duty = r_neg ? dmpi_pkg::DUTY_MIN : dmpi_pkg::DUTY_MAX;
        end else begin
            w_duty = r_neg ? -$signed({1'b0, w_mag7}) : $signed({1'b0, w_mag7});
        end
        // Anti-windup: on a clamp the error is backed out of the sum.
        if (r_zero) begin
            w_sum_next = '0;
        end else if (w_over) begin
            w_sum_next = dmpi_pkg::sat16(17'(r_s) - 17'(r_err));
        end else begin
            w_sum_next = r_s;
        end
    end

    // Position check on the distance travelled since the move began.
    always_comb begin
        w_moved = r_enc - r_pos_start;
        w_goal  = dmpi_pkg::ENC_W'(r_pos_dist);
        w_done  = r_pos_mode && (w_moved >= w_goal);
        w_busy  = r_out_valid && !i_out_ready;
    end

    // State registers: configuration, targets, sums, position mode, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_l      <= dmpi_pkg::KP_LEFT_RST;
            r_ki_l      <= dmpi_pkg::KI_LEFT_RST;
            r_kp_r      <= dmpi_pkg::KP_RIGHT_RST;
            r_ki_r      <= dmpi_pkg::KI_RIGHT_RST;
            r_rot_spd   <= dmpi_pkg::ROT_SPD_RST;
            r_str_spd   <= dmpi_pkg::STR_SPD_RST;
            r_tgt_l     <= '0;
            r_tgt_r     <= '0;
            r_sum_l     <= '0;
            r_sum_r     <= '0;
            r_pos_mode  <= 1'b0;
            r_pos_dist  <= '0;
            r_pos_start <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dmpi_pkg::REG_KP_LEFT:  r_kp_l    <= i_cfg_data;
                    dmpi_pkg::REG_KI_LEFT:  r_ki_l    <= i_cfg_data;
                    dmpi_pkg::REG_KP_RIGHT: r_kp_r    <= i_cfg_data;
                    dmpi_pkg::REG_KI_RIGHT: r_ki_r    <= i_cfg_data;
                    dmpi_pkg::REG_ROT_SPD:  r_rot_spd <= i_cfg_data;
                    dmpi_pkg::REG_STR_SPD:  r_str_spd <= i_cfg_data;
                    default: ;
                endcase
            end

            // Command decode; a tick only starts the microprogram.
            if (i_cmd_acc) begin
                unique case (i_opcode) inside
                    dmpi_pkg::OPC_STOP: begin
                        r_tgt_l <= '0; r_tgt_r <= '0; r_pos_mode <= 1'b0;
                    end
                    dmpi_pkg::OPC_AT_POS: begin
                        r_tgt_l <= '0; r_tgt_r <= '0;
                    end
                    dmpi_pkg::OPC_FWD: begin
                        r_tgt_l <= i_param; r_tgt_r <= i_param; r_pos_mode <= 1'b0;
                    end
                    dmpi_pkg::OPC_REV: begin
                        r_tgt_l    <= dmpi_pkg::neg16(i_param);
                        r_tgt_r    <= dmpi_pkg::neg16(i_param);
                        r_pos_mode <= 1'b0;
                    end
                    dmpi_pkg::OPC_CCW: begin
                        r_tgt_l <= dmpi_pkg::neg16(i_param); r_tgt_r <= i_param;
                        r_pos_mode <= 1'b0;
                    end
                    dmpi_pkg::OPC_CW: begin
                        r_tgt_l <= i_param; r_tgt_r <= dmpi_pkg::neg16(i_param);
                        r_pos_mode <= 1'b0;
                    end
                    dmpi_pkg::OPC_SET_L: begin
                        r_tgt_l <= i_param; r_pos_mode <= 1'b0;
                    end
                    dmpi_pkg::OPC_SET_R: begin
                        r_tgt_r <= i_param; r_pos_mode <= 1'b0;
                    end
                    dmpi_pkg::OPC_CCW_POS, dmpi_pkg::OPC_CW_POS,
                    dmpi_pkg::OPC_FWD_POS, dmpi_pkg::OPC_REV_POS: begin
                        case (i_opcode)
                            dmpi_pkg::OPC_CCW_POS: begin
                                r_tgt_l <= dmpi_pkg::neg16(r_rot_spd);
                                r_tgt_r <= r_rot_spd;
                            end
                            dmpi_pkg::OPC_CW_POS: begin
                                r_tgt_l <= r_rot_spd;
                                r_tgt_r <= dmpi_pkg::neg16(r_rot_spd);
                            end
                            dmpi_pkg::OPC_FWD_POS: begin
                                r_tgt_l <= r_str_spd;
                                r_tgt_r <= r_str_spd;
                            end
                            default: begin
                                r_tgt_l <= dmpi_pkg::neg16(r_str_spd);
                                r_tgt_r <= dmpi_pkg::neg16(r_str_spd);
                            end
                        endcase
                        r_pos_dist  <= i_param;
                        r_pos_start <= i_enc_count;
                        r_pos_mode  <= 1'b1;
                    end
                    default: ;
                endcase
            end

            // Sum write-back at the end of each motor's pass.
            if (i_ctrl.op == dmpi_pkg::OP_FIN) begin
                if (i_ctrl.motor == dmpi_pkg::MOT_R) begin
                    r_sum_r <= w_sum_next;
                end else begin
                    r_sum_l <= w_sum_next;
                end
            end

            // Result register: drained by the sink, loaded by the output step.
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctrl.op == dmpi_pkg::OP_OUT && !w_busy) begin
                r_out_valid <= 1'b1;
                if (w_done) begin
                    r_pos_mode <= 1'b0;
                end
            end
        end
    end

    // Working registers of the PI arithmetic and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd_acc) begin
            r_rpm_l <= i_rpm_left;
            r_rpm_r <= i_rpm_right;
            r_enc   <= i_enc_count;
        end
        case (i_ctrl.op) inside
            dmpi_pkg::OP_ERR: begin
                r_err  <= dmpi_pkg::sat16(17'(w_tgt) - 17'(w_rpm));
                r_zero <= (w_tgt == '0);
            end
            dmpi_pkg::OP_SUM: begin
                r_s <= dmpi_pkg::sat16(17'(w_sum) + 17'(r_err));
            end
            dmpi_pkg::OP_MUL1, dmpi_pkg::OP_MUL2: begin
                r_prod <= w_mul_p;
            end
            dmpi_pkg::OP_INNER: begin
                r_inner <= (IW'(r_err) <<< dmpi_pkg::QI_W) + r_prod[IW-1:0];
            end
            dmpi_pkg::OP_ABS: begin
                r_neg <= r_prod[PW-1];
                r_mag <= r_prod[PW-1] ? PW'(-r_prod) : r_prod;
            end
            dmpi_pkg::OP_FIN: begin
                if (i_ctrl.motor == dmpi_pkg::MOT_R) begin
                    r_duty_r <= w_duty;
                end else begin
                    r_duty_l <= w_duty;
                end
            end
            dmpi_pkg::OP_OUT: begin
                if (!w_busy) begin
                    r_o_duty_l <= r_duty_l;
                    r_o_duty_r <= r_duty_r;
                    r_o_at_pos <= w_done;
                end
            end
            default: ;
        endcase
    end

    // A zero target at the error step skips straight to the write-back.
    assign o_stat.zero     = (w_tgt == '0);
    assign o_stat.out_busy = w_busy;

    assign o_out_valid   = r_out_valid;
    assign o_duty_left   = r_o_duty_l;
    assign o_duty_right  = r_o_duty_r;
    assign o_at_position = r_o_at_pos;

endmodule

@@ rtl/core/dual_motor_pi_speed_position.sv @@
`timescale 1ns / 1ps
// Sequence: a tick word runs through the 15-step microprogram, which runs both motors
// through one shared multiplier; each zero target skips five steps, and a busy output
// register holds the output step. Stop and move commands update the targets when accepted.
// Acceptance: words are taken only while the sequencer is idle, so a new tick waits until
// the last one has finished its program; other commands go back to back.
// Reset: synchronous, active low; targets, sums and position clear, gains and speeds load their reset values.
// ----------------------------------------------------------------------------
// dual_motor_pi_speed_position
// Dual-motor PI speed controller with anti-windup and fixed-distance moves,
// built as a microcoded sequencer driving a shared-multiplier datapath.
// ----------------------------------------------------------------------------
module dual_motor_pi_speed_position (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dmpi_in_if.sink                         i_cmd,
    dmpi_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [dmpi_pkg::CFG_IW-1:0]     i_cfg_idx,
    input  logic [dmpi_pkg::CFG_DW-1:0]     i_cfg_data
);

    dmpi_pkg::t_ctrl w_ctrl;
    dmpi_pkg::t_stat w_stat;
    logic            w_idle;
    logic            w_acc;
    logic            w_start;

    // Words are taken only while the sequencer sits at its idle step.
    assign i_cmd.ready = w_idle;
    assign w_acc       = i_cmd.valid && w_idle;
    assign w_start     = w_acc && (i_cmd.opcode == dmpi_pkg::OPC_TICK);

    dmpi_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_idle  (w_idle)
    );

    dmpi_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_cmd_acc     (w_acc),
        .i_opcode      (i_cmd.opcode),
        .i_param       (i_cmd.param),
        .i_rpm_left    (i_cmd.rpm_left),
        .i_rpm_right   (i_cmd.rpm_right),
        .i_enc_count   (i_cmd.enc_count),
        .i_ctrl        (w_ctrl),
        .o_stat        (w_stat),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_duty_left   (o_res.duty_left),
        .o_duty_right  (o_res.duty_right),
        .o_at_position (o_res.at_position)
    );

    // Duties leave the block inside the clamp range.
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ($signed(o_res.duty_left) <= 100 && $signed(o_res.duty_left) >= -100
                      && $signed(o_res.duty_right) <= 100
                      && $signed(o_res.duty_right) >= -100))
        else $error("duty outside clamp range");

    // A new result only appears from the output step of a running program.
    a_res_from_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> !$past(w_idle))
        else $error("result raised while sequencer idle");

    // Non-tick commands never start the microprogram.
    a_cmd_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_cmd.opcode != dmpi_pkg::OPC_TICK) |=> w_idle)
        else $error("command left sequencer busy");

endmodule

@@ tb/sv/dual_motor_pi_speed_position_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_motor_pi_speed_position_tb
// Self-checking bench for the dual-motor PI controller. A driver sends command
// and tick words from a queue, a local model predicts the duty word of every
// tick, and a monitor compares each duty word field by field. Both channels
// idle at random, and the gain and move-speed registers change between phases.
// ----------------------------------------------------------------------------
module dual_motor_pi_speed_position_tb;

    localparam int     HALF_PERIOD    = 6;
    localparam int     RESET_CYCLES   = 7;
    localparam int     SETTLE_CYCLES  = 24;
    localparam int     DRAIN_CYCLES   = 32;
    localparam int     HOLD_CYCLES    = 250;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam longint SPD_HI         = 32767;
    localparam longint SPD_LO         = -32768;
    localparam longint DUTY_LIM       = 100;
    localparam longint MAG_CAP        = 1000;
    localparam int unsigned OPC_W     = dmpi_pkg::OPC_W;
    localparam int unsigned SPD_W     = dmpi_pkg::SPD_W;
    localparam int unsigned ENC_W     = dmpi_pkg::ENC_W;
    localparam int unsigned DUTY_W    = dmpi_pkg::DUTY_W;
    localparam int unsigned CFG_IW    = dmpi_pkg::CFG_IW;
    localparam int unsigned CFG_DW    = dmpi_pkg::CFG_DW;
    localparam logic [OPC_W-1:0] OPC_LAST = dmpi_pkg::OPC_REV_POS;

    // One command or tick word, with the idle cycles that come before it.
    typedef struct {
        logic [OPC_W-1:0]        opcode;
        logic signed [SPD_W-1:0] param;
        logic signed [SPD_W-1:0] rpm_left;
        logic signed [SPD_W-1:0] rpm_right;
        logic [ENC_W-1:0]        enc_count;
        int unsigned             gap;
    } t_cmd_word;

    // One duty word as the block returns it.
    typedef struct packed {
        logic signed [DUTY_W-1:0] duty_left;
        logic signed [DUTY_W-1:0] duty_right;
        logic                     at_position;
    } t_duty_word;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IW-1:0] i_cfg_idx;
    logic [CFG_DW-1:0] i_cfg_data;

    dmpi_in_if  cmd_if ();
    dmpi_out_if res_if ();

    dual_motor_pi_speed_position dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Model copy of the registers and the controller state.
    logic [CFG_DW-1:0]       gain_kp_l, gain_ki_l, gain_kp_r, gain_ki_r;
    logic signed [SPD_W-1:0] spd_rotate, spd_straight;
    logic signed [SPD_W-1:0] want_left, want_right;
    logic signed [SPD_W-1:0] acc_left, acc_right;
    logic                    moving;
    logic signed [SPD_W-1:0] move_dist;
    logic [ENC_W-1:0]        move_origin;

    t_cmd_word   pending_cmds[$];
    t_duty_word  expected_duties[$];
    t_cmd_word   live_word;
    t_duty_word  oldest;
    logic        offer;
    logic        rdy_next;
    int unsigned gap_count;
    int unsigned stall_left, hold_left, calm_left, pick;
    int unsigned holds_requested, holds_served;
    int unsigned words_queued;
    int unsigned quiet_cycles;
    int unsigned mismatches;
    logic        sender_calm;
    logic [ENC_W-1:0] enc_now;

    // Clock.
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Saturate a wide value to the signed 16-bit range.
    function automatic logic signed [SPD_W-1:0] clip16(input longint x);
        if (x > SPD_HI) x = SPD_HI;
        else if (x < SPD_LO) x = SPD_LO;
        return x[SPD_W-1:0];
    endfunction

    // Two's complement negation that wraps at the most negative speed.
    function automatic logic signed [SPD_W-1:0] negate_speed(input logic signed [SPD_W-1:0] x);
        return -x;
    endfunction

    // PI law of one motor with anti-windup and the duty clamp.
    task automatic pi_law(input logic signed [SPD_W-1:0] tgt,
                          input logic signed [SPD_W-1:0] rpm,
                          input logic [CFG_DW-1:0] kp, input logic [CFG_DW-1:0] ki,
                          inout logic signed [SPD_W-1:0] sum,
                          output logic signed [DUTY_W-1:0] duty);
        longint err, s, inner, prod, mag, d;
        if (tgt == 0) begin
            sum = '0;
            duty = '0;
        end else begin
            err = clip16(longint'(tgt) - longint'(rpm));
            s = clip16(longint'(sum) + err);
            inner = err * (longint'(1) << dmpi_pkg::QI_W) + longint'(ki) * s;
            prod = longint'(kp) * inner;
            mag = (prod < 0) ? -prod : prod;
            mag = mag >> dmpi_pkg::FRAC_W;
            if (mag > MAG_CAP) mag = MAG_CAP;
            d = (prod < 0) ? -mag : mag;
            // A clamped duty backs the error out of the sum again.
            if (d > DUTY_LIM) begin
                d = DUTY_LIM;
                s = clip16(s - err);
            end else if (d < -DUTY_LIM) begin
                d = -DUTY_LIM;
                s = clip16(s - err);
            end
            sum = s[SPD_W-1:0];
            duty = d[DUTY_W-1:0];
        end
    endtask

    // Latch a fixed-speed position move.
    task automatic begin_move(input logic signed [SPD_W-1:0] left,
                              input logic signed [SPD_W-1:0] right,
                              input logic signed [SPD_W-1:0] span,
                              input logic [ENC_W-1:0] count);
        want_left = left;
        want_right = right;
        move_dist = span;
        move_origin = count;
        moving = 1'b1;
    endtask

    // Update the model for one accepted word and queue the duty word of a tick.
    task automatic apply_command(input t_cmd_word w);
        t_duty_word res;
        logic [ENC_W-1:0] moved;
        logic [ENC_W-1:0] goal;
        case (w.opcode)
            dmpi_pkg::OPC_TICK: begin
                pi_law(want_left, w.rpm_left, gain_kp_l, gain_ki_l, acc_left,
                       res.duty_left);
                pi_law(want_right, w.rpm_right, gain_kp_r, gain_ki_r, acc_right,
                       res.duty_right);
                res.at_position = 1'b0;
                // The distance check runs after the duties and keeps the targets.
                if (moving) begin
                    moved = w.enc_count - move_origin;
                    goal = {{(ENC_W-SPD_W){move_dist[SPD_W-1]}}, move_dist};
                    if (moved >= goal) begin
                        moving = 1'b0;
                        res.at_position = 1'b1;
                    end
                end
                expected_duties.push_back(res);
            end
            dmpi_pkg::OPC_STOP: begin
                want_left = '0;
                want_right = '0;
                moving = 1'b0;
            end
            dmpi_pkg::OPC_AT_POS: begin
                want_left = '0;
                want_right = '0;
            end
            dmpi_pkg::OPC_FWD: begin
                want_left = w.param;
                want_right = w.param;
                moving = 1'b0;
            end
            dmpi_pkg::OPC_REV: begin
                want_left = negate_speed(w.param);
                want_right = negate_speed(w.param);
                moving = 1'b0;
            end
            dmpi_pkg::OPC_CCW: begin
                want_left = negate_speed(w.param);
                want_right = w.param;
                moving = 1'b0;
            end
            dmpi_pkg::OPC_CW: begin
                want_left = w.param;
                want_right = negate_speed(w.param);
                moving = 1'b0;
            end
            dmpi_pkg::OPC_SET_L: begin
                want_left = w.param;
                moving = 1'b0;
            end
            dmpi_pkg::OPC_SET_R: begin
                want_right = w.param;
                moving = 1'b0;
            end
            dmpi_pkg::OPC_CCW_POS:
                begin_move(negate_speed(spd_rotate), spd_rotate, w.param, w.enc_count);
            dmpi_pkg::OPC_CW_POS:
                begin_move(spd_rotate, negate_speed(spd_rotate), w.param, w.enc_count);
            dmpi_pkg::OPC_FWD_POS:
                begin_move(spd_straight, spd_straight, w.param, w.enc_count);
            dmpi_pkg::OPC_REV_POS:
                begin_move(negate_speed(spd_straight), negate_speed(spd_straight),
                           w.param, w.enc_count);
            default: begin
            end
        endcase
    endtask

    // Driver: offers words from the pending queue after their idle gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            gap_count = 0;
        end else begin
            offer = cmd_if.valid;
            if (cmd_if.valid && cmd_if.ready) begin
                apply_command(live_word);
                offer = 1'b0;
            end
            if (!offer && pending_cmds.size() > 0) begin
                if (gap_count < pending_cmds[0].gap) begin
                    gap_count++;
                end else begin
                    live_word = pending_cmds.pop_front();
                    gap_count = 0;
                    offer = 1'b1;
                    cmd_if.opcode <= live_word.opcode;
                    cmd_if.param <= live_word.param;
                    cmd_if.rpm_left <= live_word.rpm_left;
                    cmd_if.rpm_right <= live_word.rpm_right;
                    cmd_if.enc_count <= live_word.enc_count;
                end
            end
            cmd_if.valid <= offer;
        end
    end

    // Monitor: checks each duty word and drives ready with random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
            calm_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_duties.size() == 0) begin
                    $error("unexpected duty word: left %0d right %0d at_position %0b",
                           res_if.duty_left, res_if.duty_right, res_if.at_position);
                    mismatches++;
                end else begin
                    oldest = expected_duties.pop_front();
                    if (res_if.duty_left !== oldest.duty_left) begin
                        $error("duty_left: expected %0d, got %0d",
                               oldest.duty_left, res_if.duty_left);
                        mismatches++;
                    end
                    if (res_if.duty_right !== oldest.duty_right) begin
                        $error("duty_right: expected %0d, got %0d",
                               oldest.duty_right, res_if.duty_right);
                        mismatches++;
                    end
                    if (res_if.at_position !== oldest.at_position) begin
                        $error("at_position: expected %0b, got %0b",
                               oldest.at_position, res_if.at_position);
                        mismatches++;
                    end
                end
            end
            // A long hold-off lets the block back up into its input.
            if (holds_served != holds_requested) begin
                holds_served = holds_requested;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy_next = 1'b0;
            end else begin
                rdy_next = 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 25) stall_left = $urandom_range(1, 3);
                    else if (pick < 29) stall_left = $urandom_range(8, 40);
                    else if (pick == 99) calm_left = $urandom_range(50, 150);
                end
            end
            res_if.ready <= rdy_next;
        end
    end

    // Watchdog: ends a run in which nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
                     i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Queue one word with a random idle gap in front of it.
    task automatic push_word(input logic [OPC_W-1:0] op, input logic signed [SPD_W-1:0] prm,
                             input logic signed [SPD_W-1:0] rl,
                             input logic signed [SPD_W-1:0] rr,
                             input logic [ENC_W-1:0] enc);
        t_cmd_word w;
        int unsigned roll;
        w.opcode = op;
        w.param = prm;
        w.rpm_left = rl;
        w.rpm_right = rr;
        w.enc_count = enc;
        roll = $urandom_range(0, 99);
        if (sender_calm || roll < 55) w.gap = 0;
        else if (roll < 90) w.gap = $urandom_range(1, 3);
        else w.gap = $urandom_range(8, 40);
        pending_cmds.push_back(w);
        if (op <= OPC_LAST) words_queued++;
    endtask

    // Write one register and keep the model copy in step.
    task automatic write_reg(input dmpi_pkg::t_reg_idx idx, input logic [CFG_DW-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        case (idx)
            dmpi_pkg::REG_KP_LEFT:  gain_kp_l = value;
            dmpi_pkg::REG_KI_LEFT:  gain_ki_l = value;
            dmpi_pkg::REG_KP_RIGHT: gain_kp_r = value;
            dmpi_pkg::REG_KI_RIGHT: gain_ki_r = value;
            dmpi_pkg::REG_ROT_SPD:  spd_rotate = value;
            dmpi_pkg::REG_STR_SPD:  spd_straight = value;
            default: begin
            end
        endcase
    endtask

    task automatic load_regs(input logic [CFG_DW-1:0] kpl, input logic [CFG_DW-1:0] kil,
                             input logic [CFG_DW-1:0] kpr, input logic [CFG_DW-1:0] kir,
                             input logic [CFG_DW-1:0] rot, input logic [CFG_DW-1:0] str);
        write_reg(dmpi_pkg::REG_KP_LEFT, kpl);
        write_reg(dmpi_pkg::REG_KI_LEFT, kil);
        write_reg(dmpi_pkg::REG_KP_RIGHT, kpr);
        write_reg(dmpi_pkg::REG_KI_RIGHT, kir);
        write_reg(dmpi_pkg::REG_ROT_SPD, rot);
        write_reg(dmpi_pkg::REG_STR_SPD, str);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Write the reset values of every register.
    task automatic load_reset_regs();
        load_regs(dmpi_pkg::KP_LEFT_RST, dmpi_pkg::KI_LEFT_RST, dmpi_pkg::KP_RIGHT_RST,
                  dmpi_pkg::KI_RIGHT_RST, dmpi_pkg::ROT_SPD_RST, dmpi_pkg::STR_SPD_RST);
    endtask

    // Wait until every word is sent and every duty word is back, then settle.
    task automatic wait_idle();
        while (pending_cmds.size() > 0 || cmd_if.valid || expected_duties.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One command (or none) followed by a few ticks, or one noise word alone; most tick speeds track the targets.
    task automatic gen_sequence();
        int unsigned kind;
        int unsigned ticks;
        logic [OPC_W-1:0] op;
        logic signed [SPD_W-1:0] speed, span, hint, jl, jr;
        kind = $urandom_range(0, 99);
        sender_calm = ($urandom_range(0, 7) == 0);
        speed = SPD_W'($urandom_range(0, 300)) - SPD_W'(150);
        if ($urandom_range(0, 9) == 0) speed = SPD_W'($urandom);
        hint = speed;
        ticks = $urandom_range(1, 8);
        if (kind < 10) begin
            // Noise: any opcode with fields over their full range.
            push_word(OPC_W'($urandom_range(0, 15)), SPD_W'($urandom), SPD_W'($urandom),
                      SPD_W'($urandom), ENC_W'($urandom));
            ticks = 0;
        end else if (kind < 45) begin
            push_word(OPC_W'($urandom_range(dmpi_pkg::OPC_STOP, dmpi_pkg::OPC_SET_R)),
                      speed, SPD_W'($urandom), SPD_W'($urandom), enc_now);
        end else if (kind < 70) begin
            op = OPC_W'($urandom_range(dmpi_pkg::OPC_CCW_POS, dmpi_pkg::OPC_REV_POS));
            span = SPD_W'($urandom_range(0, 40));
            if ($urandom_range(0, 11) == 0) span = SPD_W'($urandom);
            hint = (op == dmpi_pkg::OPC_FWD_POS || op == dmpi_pkg::OPC_REV_POS) ?
                   spd_straight : spd_rotate;
            push_word(op, span, SPD_W'($urandom), SPD_W'($urandom), enc_now);
        end
        repeat (ticks) begin
            enc_now = enc_now + ENC_W'($urandom_range(0, 12));
            jl = SPD_W'($urandom_range(0, 120)) - SPD_W'(60);
            jr = SPD_W'($urandom_range(0, 120)) - SPD_W'(60);
            if ($urandom_range(0, 7) == 0)
                push_word(dmpi_pkg::OPC_TICK, SPD_W'($urandom), SPD_W'($urandom),
                          SPD_W'($urandom), enc_now);
            else
                push_word(dmpi_pkg::OPC_TICK, SPD_W'($urandom), hint + jl,
                          ($urandom_range(0, 1) ? hint : -hint) + jr, enc_now);
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned stop_at;
        stop_at = words_queued + count;
        enc_now = $urandom;
        while (words_queued < stop_at) gen_sequence();
    endtask

    // Stimulus.
    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.opcode = '0;
        cmd_if.param = '0;
        cmd_if.rpm_left = '0;
        cmd_if.rpm_right = '0;
        cmd_if.enc_count = '0;
        res_if.ready = 1'b0;
        gain_kp_l = dmpi_pkg::KP_LEFT_RST;
        gain_ki_l = dmpi_pkg::KI_LEFT_RST;
        gain_kp_r = dmpi_pkg::KP_RIGHT_RST;
        gain_ki_r = dmpi_pkg::KI_RIGHT_RST;
        spd_rotate = dmpi_pkg::ROT_SPD_RST;
        spd_straight = dmpi_pkg::STR_SPD_RST;
        want_left = '0;
        want_right = '0;
        acc_left = '0;
        acc_right = '0;
        moving = 1'b0;
        move_dist = '0;
        move_origin = '0;
        holds_requested = 0;
        holds_served = 0;
        words_queued = 0;
        mismatches = 0;
        sender_calm = 1'b0;
        enc_now = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words under the reset gains.
        push_word(dmpi_pkg::OPC_TICK, 16'sd0, 16'sd5, -16'sd5, 32'd0);
        // Full-scale target against full-scale opposite speed saturates the error.
        push_word(dmpi_pkg::OPC_FWD, 16'sd32767, 16'sd0, 16'sd0, 32'd0);
        push_word(dmpi_pkg::OPC_TICK, 16'sd0, 16'sh8000, 16'sh8000, 32'd0);
        // Reversing the most negative speed wraps back to itself.
        push_word(dmpi_pkg::OPC_REV, 16'sh8000, 16'sd0, 16'sd0, 32'd0);
        push_word(dmpi_pkg::OPC_TICK, 16'sd0, 16'sd32767, 16'sd32767, 32'd0);
        push_word(dmpi_pkg::OPC_CCW, 16'sd100, 16'sd0, 16'sd0, 32'd0);
        push_word(dmpi_pkg::OPC_TICK, 16'sd0, -16'sd90, 16'sd110, 32'd0);
        push_word(dmpi_pkg::OPC_CW, -16'sd5, 16'sd0, 16'sd0, 32'd0);
        push_word(dmpi_pkg::OPC_TICK, 16'sd0, 16'sd0, 16'sd0, 32'd0);
        // A zero target on one side clears that sum only.
        push_word(dmpi_pkg::OPC_SET_L, 16'sd0, 16'sd0, 16'sd0, 32'd0);
        push_word(dmpi_pkg::OPC_SET_R, 16'sd7, 16'sd0, 16'sd0, 32'd0);
        push_word(dmpi_pkg::OPC_TICK, 16'sd0, 16'sd3, 16'sd7, 32'd0);
        push_word(dmpi_pkg::OPC_STOP, 16'sd0, 16'sd0, 16'sd0, 32'd0);
        // Forward move of ten counts: short first, then reached.
        push_word(dmpi_pkg::OPC_FWD_POS, 16'sd10, 16'sd0, 16'sd0, 32'd1000);
        push_word(dmpi_pkg::OPC_TICK, 16'sd0, 16'sd20, 16'sd20, 32'd1005);
        push_word(dmpi_pkg::OPC_TICK, 16'sd0, 16'sd25, 16'sd25, 32'd1010);
        // A negative distance is a huge goal, met only by the largest travel.
        push_word(dmpi_pkg::OPC_REV_POS, -16'sd1, 16'sd0, 16'sd0, 32'd0);
        push_word(dmpi_pkg::OPC_TICK, 16'sd0, -16'sd25, -16'sd25, 32'hFFFF_FFFF);
        // At-pos zeroes the targets but keeps the move armed; the count wraps.
        push_word(dmpi_pkg::OPC_CW_POS, 16'sd5, 16'sd0, 16'sd0, 32'hFFFF_FFF0);
        push_word(dmpi_pkg::OPC_AT_POS, 16'sd0, 16'sd0, 16'sd0, 32'd0);
        push_word(dmpi_pkg::OPC_TICK, 16'sd0, 16'sd0, 16'sd0, 32'd5);
        // Zero distance completes on the first tick.
        push_word(dmpi_pkg::OPC_CCW_POS, 16'sd0, 16'sd0, 16'sd0, 32'd77);
        push_word(dmpi_pkg::OPC_TICK, 16'sd0, -16'sd20, 16'sd20, 32'd77);
        // Unused opcode is dropped without a duty word.
        push_word(OPC_LAST + OPC_W'($urandom_range(1, 3)), 16'sd1, 16'sd2, 16'sd3, 32'd4);
        push_word(dmpi_pkg::OPC_TICK, 16'sd0, 16'sd0, 16'sd0, 32'd0);
        run_random(60);

        // Reset values written explicitly.
        wait_idle();
        load_reset_regs();
        @(negedge i_clk);
        run_random(80);

        // Largest gains, most negative rotate speed, largest straight speed.
        wait_idle();
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF);
        @(negedge i_clk);
        run_random(70);

        // All registers at zero.
        wait_idle();
        load_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        @(negedge i_clk);
        run_random(50);

        // Random register values.
        wait_idle();
        load_regs(CFG_DW'($urandom), CFG_DW'($urandom), CFG_DW'($urandom), CFG_DW'($urandom),
                  CFG_DW'($urandom), CFG_DW'($urandom));
        @(negedge i_clk);
        run_random(80);

        // Small gains keep most duties inside the clamp.
        wait_idle();
        load_regs(CFG_DW'($urandom_range(0, 2000)), CFG_DW'($urandom_range(0, 3000)),
                  CFG_DW'($urandom_range(0, 2000)), CFG_DW'($urandom_range(0, 3000)),
                  CFG_DW'($urandom_range(0, 100)), -CFG_DW'($urandom_range(0, 100)));
        @(negedge i_clk);
        run_random(80);

        // Receiver holds off while ticks keep coming, so the input stalls.
        wait_idle();
        load_reset_regs();
        @(negedge i_clk);
        holds_requested++;
        sender_calm = 1'b1;
        push_word(dmpi_pkg::OPC_FWD, 16'sd60, 16'sd0, 16'sd0, 32'd0);
        repeat (40)
            push_word(dmpi_pkg::OPC_TICK, 16'sd0, SPD_W'($urandom_range(0, 120)),
                      SPD_W'($urandom_range(0, 120)), 32'd0);
        run_random(60);

        // Drain and report.
        while (pending_cmds.size() > 0 || cmd_if.valid || expected_duties.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_duties.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
